// File: rtl/cpqs_pkg.sv
// ----------------------------------------------------------------------------
// cpqs_pkg
// Shared types and constants for the coalescing priority queue scheduler.
// ----------------------------------------------------------------------------
package cpqs_pkg;

	localparam int NUM_CLASSES_DEF = 4;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam int CLS_W    = 3;
	localparam int KEY_W    = 16;
	localparam int TAG_W    = 16;
	localparam int CAP_W    = 5;
	localparam int FAIR_W   = 8;
	localparam int MCLS_W   = 2;
	localparam int CFG_W    = 8;
	localparam int CIDX_W   = 2;
	localparam int STS_W    = 3;
	localparam int OCLS_W   = 2;
	localparam int ODEPTH_W = 5;

	localparam logic [CIDX_W-1:0] REG_CAPACITY    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_FAIRNESS    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MAINTENANCE = 2'd2;

	localparam logic [STS_W-1:0] STS_QUEUED    = 3'd0;
	localparam logic [STS_W-1:0] STS_COALESCED = 3'd1;
	localparam logic [STS_W-1:0] STS_EVICTED   = 3'd2;
	localparam logic [STS_W-1:0] STS_DROPPED   = 3'd3;
	localparam logic [STS_W-1:0] STS_POPPED    = 3'd4;
	localparam logic [STS_W-1:0] STS_EMPTY     = 3'd5;

	localparam logic [CAP_W-1:0]  CAP_RST  = 5'd16;
	localparam logic [FAIR_W-1:0] FAIR_RST = 8'd8;
	localparam logic [MCLS_W-1:0] MCLS_RST = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_COAL = 2'd1,
		OP_INS  = 2'd2,
		OP_POP  = 2'd3
	} op_t;

	typedef struct packed {
		logic             valid;
		logic [CLS_W-1:0] cls;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		op_t              op;
		logic [CLS_W-1:0] cls;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             evict;
		logic [CLS_W-1:0] target;
		logic [CLS_W-1:0] maint;
	} cell_ctl_t;

endpackage

// File: rtl/cpqs_req_if.sv
// ----------------------------------------------------------------------------
// cpqs_req_if
// Request channel: enqueue or pop commands.
// ----------------------------------------------------------------------------
interface cpqs_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [2:0]  priority_req;
	logic [15:0] key;
	logic [15:0] tag;

	modport source (output valid, mode, priority_req, key, tag, input ready);
	modport sink   (input valid, mode, priority_req, key, tag, output ready);
endinterface

// File: rtl/cpqs_rsp_if.sv
// ----------------------------------------------------------------------------
// cpqs_rsp_if
// Response channel: one result word per command.
// ----------------------------------------------------------------------------
interface cpqs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] out_tag;
	logic [1:0]  out_class;
	logic [4:0]  depth;

	modport source (output valid, status, out_tag, out_class, depth, input ready);
	modport sink   (input valid, status, out_tag, out_class, depth, output ready);
endinterface

// File: rtl/cpqs_cell.sv
// ----------------------------------------------------------------------------
// cpqs_cell
// One slot of the sorted entry row; shifts toward either neighbor.
// ----------------------------------------------------------------------------
module cpqs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  cpqs_pkg::cell_ctl_t ctl,
	input  cpqs_pkg::entry_t    left,
	input  cpqs_pkg::entry_t    right,
	input  logic                left_le,
	input  logic                found_in,
	output cpqs_pkg::entry_t    entry,
	output logic                le,
	output logic                found_out,
	output logic                sel_match,
	output logic                is_last,
	output logic                maint_first
);
	import cpqs_pkg::*;

	entry_t entry_q;
	entry_t nxt;
	logic   match;

	assign entry       = entry_q;
	assign le          = entry_q.valid && (entry_q.cls <= ctl.cls);
	assign match       = entry_q.valid && (entry_q.key == ctl.key);
	assign sel_match   = match && !found_in;
	assign found_out   = found_in || match;
	assign is_last     = entry_q.valid && !right.valid;
	assign maint_first = entry_q.valid && (entry_q.cls == ctl.maint)
		&& !(left.valid && (left.cls == ctl.maint));

	always_comb begin
		nxt = entry_q;
		case (ctl.op)
			OP_COAL: begin
				if (sel_match) nxt.tag = ctl.tag;
			end
			OP_INS: begin
				if (!le) begin
					if (left_le) begin
						nxt.valid = 1'b1;
						nxt.cls   = ctl.cls;
						nxt.key   = ctl.key;
						nxt.tag   = ctl.tag;
					end else begin
						nxt = left;
						// The evicted last entry must not spill into a free slot.
						if (ctl.evict && !entry_q.valid) nxt.valid = 1'b0;
					end
				end
			end
			OP_POP: begin
				if (!entry_q.valid || (entry_q.cls >= ctl.target)) nxt = right;
			end
			default: nxt = entry_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= nxt;
		end
	end

endmodule

// File: rtl/coalescing_priority_queue_scheduler.sv
// ----------------------------------------------------------------------------
// coalescing_priority_queue_scheduler
// Strict priority command queue with key coalescing and maintenance fairness.
// ----------------------------------------------------------------------------
// Each command word is taken into the command register while the block is
// idle; in the next state the whole row of cells compares keys and classes
// in parallel and shifts in a single step, and no new word is taken until that
// step commits, which waits for room in the response register. The queue is
// a row of MAX_ENTRIES cells kept sorted by class and, within a class, by
// arrival; an insert opens a hole by moving the lower-priority entries one
// cell right, a pop closes one by moving entries left. A response word sits
// in an output register, and the next command word is taken while it waits.
module coalescing_priority_queue_scheduler #(
	parameter int NUM_CLASSES = cpqs_pkg::NUM_CLASSES_DEF,
	parameter int MAX_ENTRIES = cpqs_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cpqs_req_if.sink                    req,
	cpqs_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [cpqs_pkg::CIDX_W-1:0] cfg_index,
	input  logic [cpqs_pkg::CFG_W-1:0]  cfg_wdata
);
	import cpqs_pkg::*;

	localparam int DW    = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (DW > CAP_W) ? DW : CAP_W;
	localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [CAP_W-1:0]  capacity_q;
	logic [FAIR_W-1:0] fair_q;
	logic [MCLS_W-1:0] mcls_q;
	logic [FAIR_W-1:0] since_q;
	logic [DW-1:0]     depth_q;

	logic             mode_q;
	logic [CLS_W-1:0] cls_q;
	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;

	logic                rsp_valid_q;
	logic [STS_W-1:0]    status_q;
	logic [TAG_W-1:0]    otag_q;
	logic [OCLS_W-1:0]   ocls_q;
	logic [ODEPTH_W-1:0] odepth_q;

	cell_ctl_t ctl;
	entry_t    ent [MAX_ENTRIES];
	entry_t    lft [MAX_ENTRIES];
	entry_t    rgt [MAX_ENTRIES];
	logic      le_v [MAX_ENTRIES];
	logic      lle_v [MAX_ENTRIES];
	logic      fnd [MAX_ENTRIES+1];
	logic      selm_v [MAX_ENTRIES];
	logic      last_v [MAX_ENTRIES];
	logic      mf_v [MAX_ENTRIES];

	logic             commit;
	logic [CLS_W-1:0] pr_cls;
	logic [CLS_W-1:0] maint;
	logic [FAIR_W-1:0] interval;
	logic [CMP_W-1:0] cap_eff;
	logic             has_maint, any_last;
	logic [TAG_W-1:0] match_tag_unused_n;
	logic [CLS_W-1:0] match_cls, last_cls;
	logic [TAG_W-1:0] last_tag, maint_tag;
	op_t              op_c;
	logic             evict_c;
	logic [CLS_W-1:0] target_c;
	logic [STS_W-1:0] sts_c;
	logic [TAG_W-1:0] otag_c;
	logic [CLS_W-1:0] ocls_c;
	logic [DW-1:0]    depth_c;
	logic [FAIR_W-1:0] since_c;
	logic             forced;

	assign pr_cls   = (req.priority_req > LAST_CLS) ? LAST_CLS : req.priority_req;
	assign maint    = ({1'b0, mcls_q} > LAST_CLS) ? LAST_CLS : CLS_W'(mcls_q);
	assign interval = (fair_q == '0) ? FAIR_W'(1) : fair_q;

	always_comb begin
		cap_eff = (capacity_q == '0) ? CMP_W'(1) : CMP_W'(capacity_q);
		if (cap_eff > CMP_W'(MAX_ENTRIES)) cap_eff = CMP_W'(MAX_ENTRIES);
	end

	// Row of cells; the left end sees an empty left neighbor that counts as
	// "not lower", so an insert into an empty row lands in the first cell.
	assign fnd[0] = 1'b0;
	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign lft[gi]   = '0;
				assign lle_v[gi] = 1'b1;
			end else begin : g_mid
				assign lft[gi]   = ent[gi-1];
				assign lle_v[gi] = le_v[gi-1];
			end
			if (gi == MAX_ENTRIES - 1) begin : g_end
				assign rgt[gi] = '0;
			end else begin : g_nend
				assign rgt[gi] = ent[gi+1];
			end
			cpqs_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.left       (lft[gi]),
				.right      (rgt[gi]),
				.left_le    (lle_v[gi]),
				.found_in   (fnd[gi]),
				.entry      (ent[gi]),
				.le         (le_v[gi]),
				.found_out  (fnd[gi+1]),
				.sel_match  (selm_v[gi]),
				.is_last    (last_v[gi]),
				.maint_first(mf_v[gi])
			);
		end
	endgenerate

	// One-hot selections from the row, gathered by OR.
	always_comb begin
		has_maint = 1'b0;
		any_last  = 1'b0;
		match_cls = '0;
		last_cls  = '0;
		last_tag  = '0;
		maint_tag = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			has_maint = has_maint | mf_v[i];
			any_last  = any_last | last_v[i];
			match_cls = match_cls | (ent[i].cls & {CLS_W{selm_v[i]}});
			last_cls  = last_cls | (ent[i].cls & {CLS_W{last_v[i]}});
			last_tag  = last_tag | (ent[i].tag & {TAG_W{last_v[i]}});
			maint_tag = maint_tag | (ent[i].tag & {TAG_W{mf_v[i]}});
		end
	end
	assign match_tag_unused_n = '0;

	// Decision for the word held in the command register.
	always_comb begin
		op_c     = OP_NONE;
		evict_c  = 1'b0;
		target_c = '0;
		sts_c    = STS_EMPTY;
		otag_c   = match_tag_unused_n;
		ocls_c   = '0;
		depth_c  = depth_q;
		since_c  = since_q;
		forced   = (since_q >= interval) && has_maint;
		if (mode_q) begin
			if (forced) begin
				op_c     = OP_POP;
				target_c = maint;
				sts_c    = STS_POPPED;
				otag_c   = maint_tag;
				ocls_c   = maint;
				depth_c  = depth_q - DW'(1);
				since_c  = '0;
			end else if (ent[0].valid) begin
				op_c    = OP_POP;
				sts_c   = STS_POPPED;
				otag_c  = ent[0].tag;
				ocls_c  = ent[0].cls;
				depth_c = depth_q - DW'(1);
				if (ent[0].cls == maint) since_c = '0;
				else if (since_q != '1) since_c = since_q + FAIR_W'(1);
			end
		end else if ((key_q != '0) && fnd[MAX_ENTRIES]) begin
			op_c   = OP_COAL;
			sts_c  = STS_COALESCED;
			ocls_c = match_cls;
		end else if (CMP_W'(depth_q) >= cap_eff) begin
			if (any_last && (last_cls > cls_q)) begin
				op_c    = OP_INS;
				evict_c = 1'b1;
				sts_c   = STS_EVICTED;
				otag_c  = last_tag;
				ocls_c  = last_cls;
			end else begin
				sts_c = STS_DROPPED;
			end
		end else begin
			op_c    = OP_INS;
			sts_c   = STS_QUEUED;
			ocls_c  = cls_q;
			depth_c = depth_q + DW'(1);
		end
	end

	assign commit = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		ctl.op     = commit ? op_c : OP_NONE;
		ctl.cls    = cls_q;
		ctl.key    = key_q;
		ctl.tag    = tag_q;
		ctl.evict  = evict_c;
		ctl.target = target_c;
		ctl.maint  = maint;
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.out_tag   = otag_q;
	assign rsp.out_class = ocls_q;
	assign rsp.depth     = odepth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			depth_q     <= '0;
			since_q     <= '0;
			capacity_q  <= CAP_RST;
			fair_q      <= FAIR_RST;
			mcls_q      <= MCLS_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CAPACITY:    capacity_q <= cfg_wdata[CAP_W-1:0];
					REG_FAIRNESS:    fair_q     <= cfg_wdata[FAIR_W-1:0];
					REG_MAINTENANCE: mcls_q     <= cfg_wdata[MCLS_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
				depth_q     <= depth_c;
				since_q     <= since_c;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			cls_q  <= pr_cls;
			key_q  <= req.key;
			tag_q  <= req.tag;
		end
		if (commit) begin
			status_q <= sts_c;
			otag_q   <= otag_c;
			ocls_q   <= OCLS_W'(ocls_c);
			odepth_q <= ODEPTH_W'(depth_c);
		end
	end

endmodule

// File: rtl/cpqs_checker.sv
// ----------------------------------------------------------------------------
// cpqs_checker
// Port-level checks of the scheduler's response words.
// ----------------------------------------------------------------------------
module cpqs_checker #(
	parameter int MAX_ENTRIES = cpqs_pkg::MAX_ENTRIES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [15:0] out_tag,
	input logic [1:0]  out_class,
	input logic [4:0]  depth
);
	import cpqs_pkg::*;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(depth) <= MAX_ENTRIES))
		else $error("depth above the number of cells");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status <= STS_EMPTY))
		else $error("status code out of range");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == STS_EMPTY)) |-> (depth == '0 && out_tag == '0))
		else $error("empty response with entries or a tag");

	a_drop_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == STS_DROPPED)) |-> (out_tag == '0 && out_class == '0
			&& depth != '0))
		else $error("dropped response carries data or an empty queue");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(out_tag)))
		else $error("stalled response word changed");

endmodule

bind coalescing_priority_queue_scheduler cpqs_checker #(
	.MAX_ENTRIES(MAX_ENTRIES)
) u_cpqs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status   (rsp.status),
	.out_tag  (rsp.out_tag),
	.out_class(rsp.out_class),
	.depth    (rsp.depth)
);
